// ===== design/rttm_pkg.sv =====
package rttm_pkg;

    // Default build of the filter
    localparam int SAMPLES_PER_AXIS_DEF = 10;
    localparam int TRIM_EACH_END_DEF    = 2;
    localparam int SAMPLE_BITS_DEF      = 12;

    // Fixed field widths
    localparam int IN_SAMPLE_W = 12;
    localparam int MODE_W      = 2;
    localparam int MEAN_W      = 12;
    localparam int COORD_W     = 13;
    localparam int COORD_MAX   = 4095;

    localparam logic signed [COORD_W-1:0] COORD_NONE = -13'sd1;

    // Item kinds
    localparam logic ACT_POLL   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Panel drive codes
    localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_X    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_Y    = 2'd2;

    // Sequencer phase
    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_X    = 3'b010,
        PH_Y    = 3'b100
    } phase_t;

endpackage

// ===== design/rttm_insert.sv =====
module rttm_insert #(
    parameter int N     = rttm_pkg::SAMPLES_PER_AXIS_DEF,
    parameter int SB    = rttm_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W = $clog2(N)
) (
    input  logic [N-1:0][SB-1:0] store,
    input  logic [CNT_W-1:0]     count,
    input  logic [SB-1:0]        value,
    output logic [N-1:0][SB-1:0] store_next
);

    logic [N-1:0] big;

    // Flag slots that are empty or hold an entry above the new sample
    always_comb begin
        for (int i = 0; i < N; i++) begin
            big[i] = (CNT_W'(i) >= count) || (store[i] > value);
        end
    end

    // Keep entries no larger than the sample, drop the sample at the boundary, shift the rest up
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (!big[i]) begin
                store_next[i] = store[i];
            end else if (i == 0) begin
                store_next[i] = value;
            end else if (!big[i-1]) begin
                store_next[i] = value;
            end else begin
                store_next[i] = store[i-1];
            end
        end
    end

endmodule

// ===== design/rttm_mean.sv =====
module rttm_mean #(
    parameter int KEPT = rttm_pkg::SAMPLES_PER_AXIS_DEF - 2 * rttm_pkg::TRIM_EACH_END_DEF,
    parameter int SB   = rttm_pkg::SAMPLE_BITS_DEF
) (
    input  logic [KEPT-1:0][SB-1:0]     mid,
    output logic [rttm_pkg::MEAN_W-1:0] mean
);

    // Exact floor division by KEPT through a rounded-up reciprocal
    localparam int L     = $clog2(KEPT);
    localparam int SUM_W = SB + L;
    localparam int S     = SUM_W + L;
    localparam int MW    = SUM_W + 1;
    localparam int PW    = SUM_W + MW;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << S) + 64'(KEPT) - 64'd1) / 64'(KEPT);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

    logic [SUM_W-1:0] sum;
    logic [PW-1:0]    prod;
    logic [SB-1:0]    quot;

    // Add the kept samples
    always_comb begin
        sum = '0;
        for (int k = 0; k < KEPT; k++) begin
            sum = sum + SUM_W'(mid[k]);
        end
    end

    assign prod = PW'(sum) * PW'(RECIP);
    assign quot = prod[S +: SB];

    // Clamp to the coordinate range
    always_comb begin
        if (SB > rttm_pkg::MEAN_W && quot > SB'(rttm_pkg::COORD_MAX)) begin
            mean = rttm_pkg::MEAN_W'(rttm_pkg::COORD_MAX);
        end else begin
            mean = rttm_pkg::MEAN_W'(quot);
        end
    end

endmodule

// ===== design/resistive_touch_trimmed_mean.sv =====
// Channel  Direction  Beat contents
// s_       in         action, pen_up, sample
// m_       out        panel_mode, coord_valid, touched, coord_x, coord_y
//
// One beat in, one beat out; a beat may enter every cycle while the result is not stalled.
// A beat passes through an input register, then the sort insert, trimmed
// sum and reciprocal multiply land in the result registers.
// Reset clears the phase, the sample count, the held coordinates and the
// valid flags; the sample store is only read where written.
// A stalled result holds the input register, which holds s_ready low.
module resistive_touch_trimmed_mean #(
    parameter int SAMPLES_PER_AXIS = rttm_pkg::SAMPLES_PER_AXIS_DEF,
    parameter int TRIM_EACH_END    = rttm_pkg::TRIM_EACH_END_DEF,
    parameter int SAMPLE_BITS      = rttm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic                                s_pen_up,
    input  logic [rttm_pkg::IN_SAMPLE_W-1:0]    s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rttm_pkg::MODE_W-1:0]         m_panel_mode,
    output logic                                m_coord_valid,
    output logic                                m_touched,
    output logic signed [rttm_pkg::COORD_W-1:0] m_coord_x,
    output logic signed [rttm_pkg::COORD_W-1:0] m_coord_y
);

    localparam int N     = SAMPLES_PER_AXIS;
    localparam int SB    = SAMPLE_BITS;
    localparam int TRIM  = (2 * TRIM_EACH_END >= N) ? (N - 1) / 2 : TRIM_EACH_END;
    localparam int KEPT  = N - 2 * TRIM;
    localparam int CNT_W = $clog2(N);
    localparam int IN_W  = (SB < rttm_pkg::IN_SAMPLE_W) ? SB : rttm_pkg::IN_SAMPLE_W;

    // Input register
    logic          inq_valid_reg, inq_valid_next;
    logic          inq_action_reg;
    logic          inq_pen_up_reg;
    logic [SB-1:0] inq_sample_reg;

    // Sequencer state
    rttm_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic signed [rttm_pkg::COORD_W-1:0] hold_x_reg, hold_x_next;
    logic signed [rttm_pkg::COORD_W-1:0] hold_y_reg, hold_y_next;
    logic             touched_reg, touched_next;
    logic [N-1:0][SB-1:0] store_reg;

    // Result register
    logic                        m_valid_reg, m_valid_next;
    logic                        cvalid_reg, cvalid_next;
    logic [rttm_pkg::MODE_W-1:0] mode_reg, mode_next;

    logic                        advance;
    logic                        take_in;
    logic                        do_insert;
    logic [N-1:0][SB-1:0]        store_ins;
    logic [rttm_pkg::MEAN_W-1:0] mean;

    assign advance = inq_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !inq_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (take_in) begin
            inq_action_reg <= s_action;
            inq_pen_up_reg <= s_pen_up;
            inq_sample_reg <= SB'(s_sample[IN_W-1:0]);
        end
    end

    always_comb begin
        if (take_in) begin
            inq_valid_next = 1'b1;
        end else if (advance) begin
            inq_valid_next = 1'b0;
        end else begin
            inq_valid_next = inq_valid_reg;
        end
    end

    rttm_insert #(
        .N     (N),
        .SB    (SB),
        .CNT_W (CNT_W)
    ) u_insert (
        .store      (store_reg),
        .count      (count_reg),
        .value      (inq_sample_reg),
        .store_next (store_ins)
    );

    rttm_mean #(
        .KEPT (KEPT),
        .SB   (SB)
    ) u_mean (
        .mid  (store_ins[N-1-TRIM:TRIM]),
        .mean (mean)
    );

    // Step the sequencer on the buffered beat
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        hold_x_next  = hold_x_reg;
        hold_y_next  = hold_y_reg;
        touched_next = touched_reg;
        cvalid_next  = 1'b0;
        do_insert    = 1'b0;
        case (phase_reg)
            rttm_pkg::PH_WAIT: begin
                if (inq_action_reg == rttm_pkg::ACT_POLL) begin
                    if (inq_pen_up_reg) begin
                        hold_x_next  = rttm_pkg::COORD_NONE;
                        hold_y_next  = rttm_pkg::COORD_NONE;
                        touched_next = 1'b0;
                        cvalid_next  = 1'b1;
                    end else begin
                        phase_next = rttm_pkg::PH_X;
                        count_next = '0;
                    end
                end
            end
            rttm_pkg::PH_X, rttm_pkg::PH_Y: begin
                if (inq_action_reg == rttm_pkg::ACT_SAMPLE) begin
                    do_insert = 1'b1;
                    if (count_reg == CNT_W'(N - 1)) begin
                        count_next = '0;
                        if (phase_reg == rttm_pkg::PH_X) begin
                            hold_x_next = {1'b0, mean};
                            phase_next  = rttm_pkg::PH_Y;
                        end else begin
                            hold_y_next  = {1'b0, mean};
                            touched_next = 1'b1;
                            phase_next   = rttm_pkg::PH_WAIT;
                            cvalid_next  = 1'b1;
                        end
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                phase_next = rttm_pkg::PH_WAIT;
                count_next = '0;
            end
        endcase
    end

    // Map the phase to the panel drive code
    always_comb begin
        case (phase_next)
            rttm_pkg::PH_X: mode_next = rttm_pkg::MODE_X;
            rttm_pkg::PH_Y: mode_next = rttm_pkg::MODE_Y;
            default:        mode_next = rttm_pkg::MODE_WAIT;
        endcase
    end

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inq_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            phase_reg     <= rttm_pkg::PH_WAIT;
            count_reg     <= '0;
            hold_x_reg    <= rttm_pkg::COORD_NONE;
            hold_y_reg    <= rttm_pkg::COORD_NONE;
            touched_reg   <= 1'b0;
            cvalid_reg    <= 1'b0;
            mode_reg      <= rttm_pkg::MODE_WAIT;
        end else begin
            inq_valid_reg <= inq_valid_next;
            m_valid_reg   <= m_valid_next;
            if (advance) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                hold_x_reg  <= hold_x_next;
                hold_y_reg  <= hold_y_next;
                touched_reg <= touched_next;
                cvalid_reg  <= cvalid_next;
                mode_reg    <= mode_next;
            end
        end
    end

    // Hold the sorted store between samples
    always_ff @(posedge aclk) begin
        if (advance && do_insert) begin
            store_reg <= store_ins;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_panel_mode  = mode_reg;
    assign m_coord_valid = cvalid_reg;
    assign m_touched     = touched_reg;
    assign m_coord_x     = hold_x_reg;
    assign m_coord_y     = hold_y_reg;

endmodule

// ===== design/rttm_checker.sv =====
module rttm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [rttm_pkg::MODE_W-1:0]         m_panel_mode,
    input logic                                m_coord_valid,
    input logic                                m_touched,
    input logic signed [rttm_pkg::COORD_W-1:0] m_coord_x,
    input logic signed [rttm_pkg::COORD_W-1:0] m_coord_y
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coord_x) && $stable(m_coord_y)
            && $stable(m_panel_mode) && $stable(m_coord_valid))
        else $error("result beat changed while stalled");

    // A completed update always returns the panel to wait
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coord_valid |-> m_panel_mode == rttm_pkg::MODE_WAIT)
        else $error("update completed outside wait mode");

    // Waiting with no touch shows no coordinates
    a_untouched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_panel_mode == rttm_pkg::MODE_WAIT && !m_touched
            |-> m_coord_x == rttm_pkg::COORD_NONE && m_coord_y == rttm_pkg::COORD_NONE)
        else $error("coordinates present without a touch");

    // A touched update carries non-negative coordinates
    a_touched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coord_valid && m_touched
            |-> !m_coord_x[rttm_pkg::COORD_W-1] && !m_coord_y[rttm_pkg::COORD_W-1])
        else $error("touched update with negative coordinate");

endmodule

bind resistive_touch_trimmed_mean rttm_checker u_rttm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_panel_mode  (m_panel_mode),
    .m_coord_valid (m_coord_valid),
    .m_touched     (m_touched),
    .m_coord_x     (m_coord_x),
    .m_coord_y     (m_coord_y)
);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SAMPLES    = rttm_pkg::SAMPLES_PER_AXIS_DEF;
    localparam int N_TRIM       = rttm_pkg::TRIM_EACH_END_DEF;
    localparam int N_BITS       = rttm_pkg::SAMPLE_BITS_DEF;
    localparam int SMP_W        = rttm_pkg::IN_SAMPLE_W;
    localparam int CW           = rttm_pkg::COORD_W;
    localparam int SMP_TOP      = rttm_pkg::COORD_MAX;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 40;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_AFTER   = 100;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic             action;
        logic             pen_up;
        logic [SMP_W-1:0] sample;
    } touch_item_t;

    typedef struct {
        logic [rttm_pkg::MODE_W-1:0] mode;
        logic                        coord_valid;
        logic                        touched;
        logic signed [CW-1:0]        x;
        logic signed [CW-1:0]        y;
    } touch_report_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic             s_valid  = 1'b0;
    logic             s_ready;
    logic             s_action = rttm_pkg::ACT_POLL;
    logic             s_pen_up = 1'b1;
    logic [SMP_W-1:0] s_sample = '0;

    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [rttm_pkg::MODE_W-1:0] m_panel_mode;
    logic                        m_coord_valid;
    logic                        m_touched;
    logic signed [CW-1:0]        m_coord_x;
    logic signed [CW-1:0]        m_coord_y;

    touch_item_t   pending_items[$];
    touch_report_t expected_reports[$];

    int mismatch_count = 0;
    int accepted_beats = 0;
    int cycle_count    = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_cycles    = 0;
    logic long_hold    = 1'b0;

    // Shadow state of the sequencer and filter
    logic [rttm_pkg::MODE_W-1:0] pred_phase;
    int                          pred_count;
    logic [SMP_W-1:0]            pred_store[N_SAMPLES];
    logic signed [CW-1:0]        pred_x;
    logic signed [CW-1:0]        pred_y;
    logic                        pred_touched;

    resistive_touch_trimmed_mean uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_pen_up      (s_pen_up),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_panel_mode  (m_panel_mode),
        .m_coord_valid (m_coord_valid),
        .m_touched     (m_touched),
        .m_coord_x     (m_coord_x),
        .m_coord_y     (m_coord_y)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Drop the extreme samples of one axis and average what is left
    function automatic logic signed [CW-1:0] axis_trimmed_mean();
        int     trim;
        int     kept;
        longint sum;
        trim = N_TRIM;
        sum  = 0;
        if (2 * trim >= N_SAMPLES) begin
            trim = (N_SAMPLES - 1) / 2;
        end
        kept = N_SAMPLES - 2 * trim;
        for (int i = trim; i < N_SAMPLES - trim; i++) begin
            sum += pred_store[i];
        end
        sum = sum / kept;
        if (sum > SMP_TOP) begin
            sum = SMP_TOP;
        end
        return CW'(sum);
    endfunction

    // Advance the shadow sequencer by one beat and return the report it causes
    function automatic touch_report_t touch_filter_predict(touch_item_t item);
        touch_report_t    rep;
        logic [SMP_W-1:0] v;
        int               i;
        rep.coord_valid = 1'b0;
        v = item.sample & SMP_W'((1 << N_BITS) - 1);
        if (item.action == rttm_pkg::ACT_POLL) begin
            if (pred_phase == rttm_pkg::MODE_WAIT) begin
                if (item.pen_up) begin
                    pred_x          = rttm_pkg::COORD_NONE;
                    pred_y          = rttm_pkg::COORD_NONE;
                    pred_touched    = 1'b0;
                    rep.coord_valid = 1'b1;
                end else begin
                    pred_phase = rttm_pkg::MODE_X;
                    pred_count = 0;
                end
            end
        end else if (pred_phase == rttm_pkg::MODE_X || pred_phase == rttm_pkg::MODE_Y) begin
            // insert into the sorted store
            if (pred_count < N_SAMPLES) begin
                i = pred_count;
                while (i > 0 && pred_store[i-1] > v) begin
                    pred_store[i] = pred_store[i-1];
                    i--;
                end
                pred_store[i] = v;
                pred_count++;
            end
            if (pred_count >= N_SAMPLES) begin
                if (pred_phase == rttm_pkg::MODE_X) begin
                    pred_x     = axis_trimmed_mean();
                    pred_phase = rttm_pkg::MODE_Y;
                end else begin
                    pred_y          = axis_trimmed_mean();
                    pred_touched    = 1'b1;
                    pred_phase      = rttm_pkg::MODE_WAIT;
                    rep.coord_valid = 1'b1;
                end
                pred_count = 0;
            end
        end
        rep.mode    = pred_phase;
        rep.touched = pred_touched;
        rep.x       = pred_x;
        rep.y       = pred_y;
        return rep;
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample(int style, int center);
        int v;
        case (style)
            0: begin
                v = int'($urandom_range(0, SMP_TOP));
            end
            1: begin
                v = center + int'($urandom_range(0, 80)) - 40;
                if (v < 0) v = 0;
                if (v > SMP_TOP) v = SMP_TOP;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1;
                    2: v = SMP_TOP - 1;
                    default: v = SMP_TOP;
                endcase
            end
            default: begin
                v = center;
            end
        endcase
        return SMP_W'(v);
    endfunction

    task automatic queue_item(logic action, logic pen_up, logic [SMP_W-1:0] sample);
        touch_item_t item;
        item.action = action;
        item.pen_up = pen_up;
        item.sample = sample;
        pending_items.push_back(item);
    endtask

    // Sender: offer pending beats, with random idle bursts until the tail
    always @(posedge aclk) begin : driver
        touch_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                item.action = s_action;
                item.pen_up = s_pen_up;
                item.sample = s_sample;
                expected_reports.push_back(touch_filter_predict(item));
                accepted_beats++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 17) - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                item = pending_items.pop_front();
                s_valid  <= 1'b1;
                s_action <= item.action;
                s_pen_up <= item.pen_up;
                s_sample <= item.sample;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Hold the receiver off once for a long stretch so the input stalls
    always @(posedge aclk) begin
        if (aresetn && accepted_beats >= HOLD_AFTER && hold_cycles < LONG_HOLD) begin
            long_hold   <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else begin
            long_hold <= 1'b0;
        end
    end

    // Receiver: random stall bursts until the tail
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 6) == 0) begin
            recv_gap = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expected report
    always @(posedge aclk) begin : monitor
        touch_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected beat: mode %0d valid %0d touched %0d x %0d y %0d",
                             m_panel_mode, m_coord_valid, m_touched, m_coord_x, m_coord_y);
                end
            end else begin
                want = expected_reports.pop_front();
                if (m_panel_mode !== want.mode || m_coord_valid !== want.coord_valid ||
                    m_touched !== want.touched || m_coord_x !== want.x ||
                    m_coord_y !== want.y) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: expected mode %0d valid %0d touched %0d x %0d y %0d",
                                 want.mode, want.coord_valid, want.touched, want.x, want.y);
                        $display("          actual   mode %0d valid %0d touched %0d x %0d y %0d",
                                 m_panel_mode, m_coord_valid, m_touched, m_coord_x, m_coord_y);
                    end
                end
            end
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int counted;
        int pick;
        int style;
        int center;
        int cut;

        pred_phase   = rttm_pkg::MODE_WAIT;
        pred_count   = 0;
        pred_x       = rttm_pkg::COORD_NONE;
        pred_y       = rttm_pkg::COORD_NONE;
        pred_touched = 1'b0;

        // Directed: pen-up poll, ignored items, extreme samples, saturated mean
        queue_item(rttm_pkg::ACT_POLL, 1'b1, 12'h000);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b0, 12'hFFF);
        queue_item(rttm_pkg::ACT_POLL, 1'b0, 12'hFFF);
        queue_item(rttm_pkg::ACT_POLL, 1'b1, 12'h000);
        queue_item(rttm_pkg::ACT_POLL, 1'b0, 12'h555);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b1, 12'h000);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b0, 12'hFFF);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b1, 12'h800);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b0, 12'h001);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b1, 12'hFFE);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b0, 12'hAAA);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b1, 12'h555);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b0, 12'h064);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b1, 12'hFA0);
        queue_item(rttm_pkg::ACT_SAMPLE, 1'b0, 12'h7FF);
        for (int k = 0; k < N_SAMPLES; k++) begin
            queue_item(rttm_pkg::ACT_SAMPLE, k[0], 12'hFFF);
        end

        // Random: mostly full touch sequences, some pen-up polls and noise
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                queue_item(rttm_pkg::ACT_POLL, 1'b1, SMP_W'($urandom_range(0, SMP_TOP)));
                counted++;
            end else if (pick < 5) begin
                queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           SMP_W'($urandom_range(0, SMP_TOP)));
            end else begin
                style  = $urandom_range(0, 3);
                center = $urandom_range(0, SMP_TOP);
                cut    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * N_SAMPLES - 1)
                                                     : 2 * N_SAMPLES;
                queue_item(rttm_pkg::ACT_POLL, 1'b0, SMP_W'($urandom_range(0, SMP_TOP)));
                counted++;
                for (int k = 0; k < cut; k++) begin
                    if (k == N_SAMPLES) begin
                        center = $urandom_range(0, SMP_TOP);
                    end
                    if ($urandom_range(0, 15) == 0) begin
                        queue_item(rttm_pkg::ACT_POLL, 1'($urandom_range(0, 1)),
                                   SMP_W'($urandom_range(0, SMP_TOP)));
                    end
                    queue_item(rttm_pkg::ACT_SAMPLE, 1'($urandom_range(0, 1)),
                               pick_sample(style, center));
                    counted++;
                end
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid || expected_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
